// ----- rtl/core/fgtr_pkg.sv -----
// ----------------------------------------------------------------------------
// fgtr_pkg
// shared constants, field positions and control structs of the glyph renderer
// ----------------------------------------------------------------------------
package fgtr_pkg;

    // font store geometry
    localparam int FONT_BYTES = 8192;
    localparam int FONT_AW    = $clog2(FONT_BYTES);
    localparam int GLYPH_ROWS = 16;
    localparam int ROW_W      = $clog2(GLYPH_ROWS);

    // field widths
    localparam int CMD_W    = 1;
    localparam int CODE_W   = 8;
    localparam int FIDX_W   = 13;
    localparam int FBYTE_W  = 8;
    localparam int ADDR_W   = 48;
    localparam int PITCH_W  = 14;
    localparam int SWIDTH_W = 14;
    localparam int GBYTES_W = 6;
    localparam int COLOUR_W = 32;
    localparam int MASK_W   = 8;
    localparam int CUR_W    = 16;
    localparam int PROD_W   = CUR_W + PITCH_W;
    localparam int GBASE_W  = CODE_W + GBYTES_W;

    // input tdata layout
    localparam int S_DATA_W   = 32;
    localparam int CODE_LSB   = 0;
    localparam int FIDX_LSB   = CODE_LSB + CODE_W;
    localparam int FBYTE_LSB  = FIDX_LSB + FIDX_W;

    // output tdata layout
    localparam int M_DATA_W   = 88;
    localparam int RADDR_LSB  = 0;
    localparam int MASK_LSB   = RADDR_LSB + ADDR_W;
    localparam int COLOUR_LSB = MASK_LSB + MASK_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ADDR_W;

    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GBYTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR = 3'd4;

    // command codes
    localparam logic CMD_PRINT = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    // reset values
    localparam logic [ADDR_W-1:0]   BASE_RST   = '0;
    localparam logic [PITCH_W-1:0]  PITCH_RST  = 14'd1024;
    localparam logic [SWIDTH_W-1:0] SWIDTH_RST = 14'd1024;
    localparam logic [GBYTES_W-1:0] GBYTES_RST = 6'd16;
    localparam logic [COLOUR_W-1:0] COLOUR_RST = 32'hffff_ffff;
    localparam logic [CUR_W-1:0]    CUR_X_RST  = 16'd50;
    localparam logic [CUR_W-1:0]    CUR_Y_RST  = 16'd120;

    // cursor steps
    localparam logic [CUR_W-1:0] CHAR_ADV = 16'd8;
    localparam logic [CUR_W-1:0] LINE_ADV = 16'd16;

    // controller to datapath
    typedef struct packed {
        logic load_wr;     // write one font byte from the input item
        logic capture;     // latch char code of a print item
        logic mul;         // form cursor_y * pitch and code * glyph_bytes
        logic addr;        // form first row address, advance cursor
        logic issue;       // read one glyph row into the pipe
        logic issue_last;  // the row issued is the final one
    } fgtr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic can_issue;   // read stage is free to take a row
    } fgtr_status_t;

endpackage

// ----- rtl/core/fgtr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fgtr_ctrl
// item sequencer: accepts items, runs setup and steps through glyph rows
// ----------------------------------------------------------------------------
module fgtr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 command,
    input  fgtr_pkg::fgtr_status_t status,
    output logic                 ready,
    output fgtr_pkg::fgtr_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_ADDR  = 2'd2;
    localparam logic [1:0] ST_ISSUE = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [fgtr_pkg::ROW_W-1:0] row_reg, row_next;
    logic                       accept;
    logic                       row_last;

    assign ready    = (state_reg == ST_IDLE);
    assign accept   = ready && s_tvalid;
    assign row_last = (row_reg == fgtr_pkg::ROW_W'(fgtr_pkg::GLYPH_ROWS - 1));

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        cmd.load_wr    = accept && (command == fgtr_pkg::CMD_LOAD);
        cmd.capture    = accept && (command == fgtr_pkg::CMD_PRINT);
        cmd.mul        = 1'b0;
        cmd.addr       = 1'b0;
        cmd.issue      = 1'b0;
        cmd.issue_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                row_next   = '0;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (status.can_issue)
                begin
                    cmd.issue      = 1'b1;
                    cmd.issue_last = row_last;
                    row_next       = row_reg + 1'b1;
                    if (row_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

endmodule

// ----- rtl/core/fgtr_datapath.sv -----
// ----------------------------------------------------------------------------
// fgtr_datapath
// config registers, cursor, glyph store, row address and output register
// ----------------------------------------------------------------------------
module fgtr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fgtr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fgtr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [fgtr_pkg::S_DATA_W-1:0]       s_tdata,
    input  fgtr_pkg::fgtr_cmd_t                 cmd,
    output fgtr_pkg::fgtr_status_t              status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fgtr_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    // configuration
    logic [fgtr_pkg::ADDR_W-1:0]   base_reg;
    logic [fgtr_pkg::PITCH_W-1:0]  pitch_reg;
    logic [fgtr_pkg::SWIDTH_W-1:0] swidth_reg;
    logic [fgtr_pkg::GBYTES_W-1:0] gbytes_reg;
    logic [fgtr_pkg::COLOUR_W-1:0] colour_reg;

    // cursor
    logic [fgtr_pkg::CUR_W-1:0] cur_x_reg, cur_x_next;
    logic [fgtr_pkg::CUR_W-1:0] cur_y_reg, cur_y_next;
    logic [fgtr_pkg::CUR_W-1:0] x_adv;
    logic                       wrap;

    // setup and row walk
    logic [fgtr_pkg::CODE_W-1:0]  code_reg;
    logic [fgtr_pkg::PROD_W-1:0]  prod_reg;
    logic [fgtr_pkg::GBASE_W-1:0] gbase_reg;
    logic [fgtr_pkg::ADDR_W-1:0]  addr_reg;
    logic [fgtr_pkg::FONT_AW-1:0] gaddr_reg;

    // glyph store
    logic [fgtr_pkg::FBYTE_W-1:0] glyph_mem [fgtr_pkg::FONT_BYTES];
    logic [fgtr_pkg::FBYTE_W-1:0] rdata_reg;
    logic [fgtr_pkg::FONT_AW-1:0] waddr;

    // read stage and output register
    logic                          pend_valid_reg, pend_valid_next;
    logic [fgtr_pkg::ADDR_W-1:0]   pend_addr_reg;
    logic                          pend_last_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [fgtr_pkg::ADDR_W-1:0]   out_addr_reg;
    logic [fgtr_pkg::MASK_W-1:0]   out_mask_reg;
    logic [fgtr_pkg::COLOUR_W-1:0] out_colour_reg;
    logic                          out_last_reg;
    logic                          out_load;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= fgtr_pkg::BASE_RST;
            pitch_reg  <= fgtr_pkg::PITCH_RST;
            swidth_reg <= fgtr_pkg::SWIDTH_RST;
            gbytes_reg <= fgtr_pkg::GBYTES_RST;
            colour_reg <= fgtr_pkg::COLOUR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fgtr_pkg::REG_BASE:   base_reg   <= cfg_data[fgtr_pkg::ADDR_W-1:0];
                fgtr_pkg::REG_PITCH:  pitch_reg  <= cfg_data[fgtr_pkg::PITCH_W-1:0];
                fgtr_pkg::REG_SWIDTH: swidth_reg <= cfg_data[fgtr_pkg::SWIDTH_W-1:0];
                fgtr_pkg::REG_GBYTES: gbytes_reg <= cfg_data[fgtr_pkg::GBYTES_W-1:0];
                fgtr_pkg::REG_COLOUR: colour_reg <= cfg_data[fgtr_pkg::COLOUR_W-1:0];
                default:              ;
            endcase
        end
    end

    // cursor advance with line wrap
    assign x_adv = cur_x_reg + fgtr_pkg::CHAR_ADV;
    assign wrap  = ({1'b0, x_adv} + {1'b0, fgtr_pkg::CHAR_ADV})
                   > (fgtr_pkg::CUR_W + 1)'(swidth_reg);

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (cmd.addr)
        begin
            if (wrap)
            begin
                cur_x_next = '0;
                cur_y_next = cur_y_reg + fgtr_pkg::LINE_ADV;
            end
            else
            begin
                cur_x_next = x_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= fgtr_pkg::CUR_X_RST;
            cur_y_reg <= fgtr_pkg::CUR_Y_RST;
        end
        else
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
        end
    end

    // setup: products, then first row address; rows step by the pitch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            code_reg <= s_tdata[fgtr_pkg::CODE_LSB +: fgtr_pkg::CODE_W];
        end
        if (cmd.mul)
        begin
            prod_reg  <= cur_y_reg * pitch_reg;
            gbase_reg <= code_reg * gbytes_reg;
        end
        if (cmd.addr)
        begin
            addr_reg  <= base_reg + fgtr_pkg::ADDR_W'(cur_x_reg)
                         + fgtr_pkg::ADDR_W'(prod_reg);
            gaddr_reg <= fgtr_pkg::FONT_AW'(gbase_reg);
        end
        else if (cmd.issue)
        begin
            addr_reg  <= addr_reg + fgtr_pkg::ADDR_W'(pitch_reg);
            gaddr_reg <= gaddr_reg + 1'b1;
        end
    end

    // glyph store, one write and one registered read port
    assign waddr = fgtr_pkg::FONT_AW'(s_tdata[fgtr_pkg::FIDX_LSB +: fgtr_pkg::FIDX_W]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
        begin
            glyph_mem[waddr] <= s_tdata[fgtr_pkg::FBYTE_LSB +: fgtr_pkg::FBYTE_W];
        end
        if (cmd.issue)
        begin
            rdata_reg <= glyph_mem[gaddr_reg];
        end
    end

    // read stage feeds the output register
    assign out_load         = pend_valid_reg && (!out_valid_reg || m_tready);
    assign status.can_issue = !pend_valid_reg || out_load;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (cmd.issue)
        begin
            pend_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            pend_addr_reg <= addr_reg;
            pend_last_reg <= cmd.issue_last;
        end
        if (out_load)
        begin
            out_addr_reg   <= pend_addr_reg;
            out_mask_reg   <= rdata_reg;
            out_colour_reg <= colour_reg;
            out_last_reg   <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_colour_reg, out_mask_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/core/font_glyph_text_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// font_glyph_text_renderer_unit
// 8-pixel-wide bitmap font text renderer producing frame buffer row writes
// ----------------------------------------------------------------------------
// A load item (tuser high) writes one byte of the 8192-byte glyph store as it
// is accepted. A print item (tuser low) draws one character at the text
// cursor: sixteen row writes, each with the pixel word address of the row's
// leftmost pixel, an 8-bit mask (bit 7 leftmost) and the pen colour, tlast on
// the sixteenth. Rows with an all-zero mask are still sent. After the rows
// are set up the cursor moves right by 8 and wraps to the next 16-pixel line
// when the next glyph would pass screen_width; nothing is clipped. A print
// occupies the input side through the accept cycle, the cursor_y * row_pitch
// and code * glyph_bytes products, the first row address, then sixteen glyph
// store reads at one per cycle while the output is not stalled, through the
// store's single read port. The output register lets rows drain while the
// next item is accepted; back-pressure on the master side stalls the reads.
// The glyph store has no reset: bytes must be loaded before they are drawn.
// Configuration writes are taken at any edge with cfg_we high and must only
// be made while no print is in flight.
// ----------------------------------------------------------------------------
module font_glyph_text_renderer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [fgtr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fgtr_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fgtr_pkg::S_DATA_W-1:0]       s_tdata,  // char_code, font_index, font_byte
    input  logic                                s_tuser,  // command
    // row writes
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fgtr_pkg::M_DATA_W-1:0]       m_tdata,  // row_address, pixel_mask, colour
    output logic                                m_tlast   // last row of the character
);

    fgtr_pkg::fgtr_cmd_t    cmd;
    fgtr_pkg::fgtr_status_t status;

    // sequencer: item accept, setup steps, row issue count
    fgtr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .command  (s_tuser),
        .status   (status),
        .ready    (s_tready),
        .cmd      (cmd)
    );

    // registers, cursor, glyph store and row pipe
    fgtr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/core/fgtr_checker.sv -----
// ----------------------------------------------------------------------------
// fgtr_checker
// port-level checks of the glyph renderer, bound to the top level
// ----------------------------------------------------------------------------
module fgtr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fgtr_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    logic [fgtr_pkg::ROW_W-1:0] rows_reg;

    // rows delivered within the current character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            rows_reg <= rows_reg + 1'b1;
        end
    end

    // a stalled row write holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("row write changed while stalled");

    // tlast marks exactly the sixteenth row
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (rows_reg == fgtr_pkg::ROW_W'(fgtr_pkg::GLYPH_ROWS - 1))))
        else $error("tlast out of place");

    // a print holds off the next item
    a_print_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == fgtr_pkg::CMD_PRINT) |=> !s_tready ##1 !s_tready)
        else $error("item taken during print setup");

    // a load leaves the input side free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == fgtr_pkg::CMD_LOAD) |=> s_tready)
        else $error("load item stalled the input");

endmodule

bind font_glyph_text_renderer_unit fgtr_checker u_fgtr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- dv/fgtr_row_checker.sv -----
// ----------------------------------------------------------------------------
// fgtr_row_checker
// predicts the row writes of the glyph renderer and compares every one
// ----------------------------------------------------------------------------
module fgtr_row_checker
    import fgtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  m_tlast,
    output int                    errors,
    output int                    rows_due,
    output int                    rows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [MASK_W-1:0]   mask;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } row_write_t;

    row_write_t rows_q[$];

    // shadow registers and state
    logic [ADDR_W-1:0]   base;
    logic [PITCH_W-1:0]  pitch;
    logic [SWIDTH_W-1:0] width;
    logic [GBYTES_W-1:0] gbytes;
    logic [COLOUR_W-1:0] colour;
    logic [FBYTE_W-1:0]  font [FONT_BYTES];
    logic [CUR_W-1:0]    cur_x;
    logic [CUR_W-1:0]    cur_y;

    task automatic report(input string what, input logic [ADDR_W-1:0] want,
                          input logic [ADDR_W-1:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    // sixteen row writes at the cursor, then cursor advance with line wrap
    task automatic draw_char(input logic [CODE_W-1:0] code);
        row_write_t          w;
        logic [FONT_AW-1:0]  gaddr;
        logic [ADDR_W-1:0]   line;
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            gaddr    = FONT_AW'(int'(code) * int'(gbytes) + r);
            line     = ADDR_W'(cur_y) + ADDR_W'(r);
            w.addr   = base + ADDR_W'(cur_x) + line * ADDR_W'(pitch);
            w.mask   = font[gaddr];
            w.colour = colour;
            w.last   = (r == GLYPH_ROWS - 1);
            rows_q.push_back(w);
        end
        cur_x = cur_x + CHAR_ADV;
        if (int'(cur_x) + int'(CHAR_ADV) > int'(width))
        begin
            cur_x = '0;
            cur_y = cur_y + LINE_ADV;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        row_write_t got;
        row_write_t want;
        if (!rst_n)
        begin
            rows_q.delete();
            base      = BASE_RST;
            pitch     = PITCH_RST;
            width     = SWIDTH_RST;
            gbytes    = GBYTES_RST;
            colour    = COLOUR_RST;
            cur_x     = CUR_X_RST;
            cur_y     = CUR_Y_RST;
            errors    = 0;
            rows_seen = 0;
        end
        else
        begin
            // results first: a row cannot belong to an item taken at this edge
            if (m_tvalid && m_tready)
            begin
                got.addr   = m_tdata[RADDR_LSB +: ADDR_W];
                got.mask   = m_tdata[MASK_LSB +: MASK_W];
                got.colour = m_tdata[COLOUR_LSB +: COLOUR_W];
                got.last   = m_tlast;
                rows_seen++;
                if (rows_q.size() == 0)
                    report("unexpected row write, address", '0, got.addr);
                else
                begin
                    want = rows_q.pop_front();
                    if (got.addr !== want.addr)
                        report("row_address", want.addr, got.addr);
                    if (got.mask !== want.mask)
                        report("pixel_mask", ADDR_W'(want.mask), ADDR_W'(got.mask));
                    if (got.colour !== want.colour)
                        report("colour", ADDR_W'(want.colour), ADDR_W'(got.colour));
                    if (got.last !== want.last)
                        report("last", ADDR_W'(want.last), ADDR_W'(got.last));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == CMD_LOAD)
                    font[s_tdata[FIDX_LSB +: FIDX_W]] = s_tdata[FBYTE_LSB +: FBYTE_W];
                else
                    draw_char(s_tdata[CODE_LSB +: CODE_W]);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE:   base   = cfg_data[ADDR_W-1:0];
                    REG_PITCH:  pitch  = cfg_data[PITCH_W-1:0];
                    REG_SWIDTH: width  = cfg_data[SWIDTH_W-1:0];
                    REG_GBYTES: gbytes = cfg_data[GBYTES_W-1:0];
                    REG_COLOUR: colour = cfg_data[COLOUR_W-1:0];
                    default:    ;
                endcase
            end
        end
        rows_due = rows_q.size();
    end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the glyph renderer, checking done beside the block
// ----------------------------------------------------------------------------
// font loads and character prints go in through the input stream while the
// row writes are drained with random stalls; a separate checker predicts
// every row write and compares it field by field. the run walks through
// reset values, register extremes, random settings and one back-to-back run
// in which every character starts a new text line
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fgtr_pkg::*;

    localparam int SETTLE = 40;     // cycles after the last row, loads make no rows
    localparam int LIMIT  = 2000;   // cycles without any item moving
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // glyph 0 pattern: blank rows, full rows, single edge pixels
    localparam logic [127:0] GLYPH0 = 128'h00ff_8001_aa55_0018_3c7e_ff00_8181_0000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    int errors;
    int rows_due;
    int rows_seen;

    // stimulus bookkeeping
    bit loaded [FONT_BYTES];    // glyph store bytes written so far
    int glyph_len;              // glyph_bytes as last written
    bit gaps_on;                // random idling on both sides
    int items_sent = 0;
    int prints_sent = 0;
    int quiet = 0;

    always #1 clk = ~clk;

    font_glyph_text_renderer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    fgtr_row_checker row_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .errors    (errors),
        .rows_due  (rows_due),
        .rows_seen (rows_seen)
    );

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // one input item; valid stays high into the next item when no gap is drawn
    task automatic send_item(input logic cmd, input logic [CODE_W-1:0] code,
                             input logic [FIDX_W-1:0] fidx, input logic [FBYTE_W-1:0] fbyte);
        int                  gap;
        logic [S_DATA_W-1:0] d;
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        d = '0;
        d[CODE_LSB +: CODE_W]   = code;
        d[FIDX_LSB +: FIDX_W]   = fidx;
        d[FBYTE_LSB +: FBYTE_W] = fbyte;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // the unused char_code field of a load is random so its bits still toggle
    task automatic load_byte(input logic [FIDX_W-1:0] idx, input logic [FBYTE_W-1:0] value);
        send_item(CMD_LOAD, CODE_W'($urandom_range(0, 255)), idx, value);
        loaded[idx] = 1'b1;
    endtask

    // well-formed print: fill in any glyph byte not yet written, then draw
    task automatic print_char(input logic [CODE_W-1:0] code);
        int idx;
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            idx = (int'(code) * glyph_len + r) % FONT_BYTES;
            if (!loaded[idx])
                load_byte(FIDX_W'(idx), FBYTE_W'($urandom_range(0, 255)));
        end
        send_item(CMD_PRINT, code, FIDX_W'($urandom_range(0, 8191)),
                  FBYTE_W'($urandom_range(0, 255)));
        prints_sent++;
    endtask

    // hold off input until every row is out, then let the pipe empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (rows_due != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // narrow registers get random upper bits, which the block must drop
    task automatic apply_config(input logic [ADDR_W-1:0] base, input logic [PITCH_W-1:0] pitch,
                                input logic [SWIDTH_W-1:0] width,
                                input logic [GBYTES_W-1:0] gbytes,
                                input logic [COLOUR_W-1:0] colour);
        logic [CFG_DATA_W-1:0] v;
        write_reg(REG_UNUSED, rand48());
        write_reg(REG_BASE, base);
        v = rand48();
        v[PITCH_W-1:0] = pitch;
        write_reg(REG_PITCH, v);
        v = rand48();
        v[SWIDTH_W-1:0] = width;
        write_reg(REG_SWIDTH, v);
        v = rand48();
        v[GBYTES_W-1:0] = gbytes;
        write_reg(REG_GBYTES, v);
        v = rand48();
        v[COLOUR_W-1:0] = colour;
        write_reg(REG_COLOUR, v);
        cfg_we <= 1'b0;
        glyph_len = int'(gbytes);
        @(posedge clk);
    endtask

    task automatic random_config();
        logic [SWIDTH_W-1:0] w;
        logic [GBYTES_W-1:0] g;
        // small widths force frequent line wraps
        case ($urandom_range(0, 2))
            0:       w = SWIDTH_W'($urandom_range(0, 15));
            1:       w = SWIDTH_W'($urandom_range(16, 400));
            default: w = SWIDTH_W'($urandom_range(0, 16383));
        endcase
        g = ($urandom_range(0, 7) == 0) ? GBYTES_W'($urandom_range(0, 63))
                                        : GBYTES_W'($urandom_range(16, 32));
        apply_config(rand48(), PITCH_W'($urandom_range(0, 16383)), w, g, $urandom);
    endtask

    // mostly prints from a small pool of codes so loads pay off in row writes,
    // mixed with stray loads and fresh codes
    task automatic random_run(input int n);
        int                stop;
        logic [CODE_W-1:0] pool [4];
        logic [FIDX_W-1:0] idx;
        stop = items_sent + n;
        foreach (pool[i]) pool[i] = CODE_W'($urandom_range(0, 255));
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 15) == 0)
                gaps_on = !gaps_on;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    idx = FIDX_W'($urandom_range(0, 8191));
                    load_byte(idx, FBYTE_W'($urandom_range(0, 255)));
                end
                2:       print_char(CODE_W'($urandom_range(0, 255)));
                default: print_char(pool[$urandom_range(0, 3)]);
            endcase
        end
        gaps_on = 1'b1;
    endtask

    // receiver: a random stall after each row write taken while idling is on
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                stall = gaps_on ? $urandom_range(0, 17) : 0;
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // watchdog: nothing moving for too long ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet <= 0;
        else if (quiet >= LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        gaps_on   = 1'b1;
        glyph_len = int'(GBYTES_RST);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: glyph 0 with blank and edge rows, drawn twice
        for (int r = 0; r < GLYPH_ROWS; r++)
            load_byte(FIDX_W'(r), GLYPH0[r*8 +: 8]);
        print_char(8'd0);
        print_char(8'd0);
        // top store byte, and a print whose unused fields are all ones
        load_byte(13'h1fff, 8'hff);
        send_item(CMD_PRINT, 8'd0, 13'h1fff, 8'hff);
        prints_sent++;
        wait_idle();

        // largest base, pitch and width: addresses wrap at 48 bits
        apply_config(48'hffff_ffff_ffff, 14'h3fff, 14'h3fff, 6'd32, 32'h0);
        print_char(8'hff);
        print_char(8'h00);
        random_run(30);
        wait_idle();

        // all zero but colour: every code reads glyph 0, every character starts a line
        apply_config(48'h0, 14'h0, 14'h0, 6'd0, $urandom);
        print_char(8'h00);
        random_run(25);
        wait_idle();

        // widest glyph step, read addresses wrap round the store
        apply_config(rand48(), 14'd1, 14'd8, 6'd63, 32'hffff_ffff);
        print_char(8'hff);
        random_run(25);
        wait_idle();

        repeat (4)
        begin
            random_config();
            random_run(25);
            wait_idle();
        end

        // zero width, no idling: each print moves down one text line
        gaps_on = 1'b0;
        apply_config(rand48(), 14'h3fff, 14'd0, 6'd16, $urandom);
        repeat (20) print_char(8'h41);
        gaps_on = 1'b1;
        wait_idle();

        $display("summary: %0d items sent (%0d prints), %0d row writes checked",
                 items_sent, prints_sent, rows_seen);
        $display("summary: reset, extreme, zero and random settings plus back-to-back line feeds");
        if (errors == 0 && rows_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
